FILE: hdl/p2ti_pkg.sv
// ----------------------------------------------------------------------------
// p2ti_pkg
// Shared widths, types and helpers of the quadratic triangle interpolator.
// ----------------------------------------------------------------------------
package p2ti_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  localparam int Q_W       = 32;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF_Q    = 1 << (FRAC_BITS - 1);

  // datapath widths
  localparam int D_W    = Q_W + 1;          // point minus origin
  localparam int MP_W   = Q_W + D_W;        // map coefficient times delta
  localparam int MS_W   = MP_W + 1;         // sum of two map products
  localparam int S_W    = Q_W + 2;          // s = one - a - b
  localparam int T0_W   = S_W + 1;          // 2s - one
  localparam int T1_W   = Q_W + 2;          // 2a - one, 2b - one
  localparam int SH_W   = S_W + T0_W + 1;   // shape function value
  localparam int SPLIT  = 35;               // low part of a shape value
  localparam int HI_W   = SH_W - SPLIT;
  localparam int PLO_W  = Q_W + SPLIT + 1;
  localparam int PHI_W  = Q_W + HI_W;
  localparam int ACC_W  = 104;              // dot product accumulator
  localparam int NODES  = 6;

  // configuration register index
  localparam int CFG_IDX_W = 3;

  typedef logic signed [Q_W-1:0]  q_t;
  typedef logic signed [SH_W-1:0] sh_t;
  typedef q_t  [NODES-1:0] node_vec_t;
  typedef sh_t [NODES-1:0] shape_vec_t;

  localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(1) << (2*FRAC_BITS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_MAP_A_X  = 3'd2,
    REG_MAP_A_Y  = 3'd3,
    REG_MAP_B_X  = 3'd4,
    REG_MAP_B_Y  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    q_t origin_x;
    q_t origin_y;
    q_t map_a_x;
    q_t map_a_y;
    q_t map_b_x;
    q_t map_b_y;
  } map_cfg_t;

  typedef struct packed {
    q_t        point_x;
    q_t        point_y;
    node_vec_t node;
  } sample_t;

  typedef struct packed {
    q_t        a;
    q_t        b;
    logic      sat;
    node_vec_t node;
  } ref_pt_t;

  typedef struct packed {
    shape_vec_t shape;
    logic       sat;
    node_vec_t  node;
  } shape_pt_t;

  typedef struct packed {
    q_t   interpolated;
    logic overflow;
  } result_t;

  typedef struct packed {
    q_t   value;
    logic clip;
  } sat_q_t;

  // clip a wide signed value to the 32-bit range
  function automatic sat_q_t sat_q(input logic signed [ACC_W-1:0] v);
    sat_q_t r;
    logic   fits;
    fits   = (v[ACC_W-1:Q_W-1] == '0) || (v[ACC_W-1:Q_W-1] == '1);
    r.clip = !fits;
    if (fits) begin
      r.value = v[Q_W-1:0];
    end else if (v[ACC_W-1]) begin
      r.value = Q_MIN;
    end else begin
      r.value = Q_MAX;
    end
    return r;
  endfunction

endpackage

FILE: hdl/p2ti_ifs.sv
// ----------------------------------------------------------------------------
// p2ti interfaces
// Sample, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface p2ti_sample_if;
  import p2ti_pkg::*;
  logic valid;
  logic ready;
  q_t   point_x;
  q_t   point_y;
  q_t   node_value_0;
  q_t   node_value_1;
  q_t   node_value_2;
  q_t   node_value_3;
  q_t   node_value_4;
  q_t   node_value_5;

  modport source (
    output valid, point_x, point_y, node_value_0, node_value_1, node_value_2,
    output node_value_3, node_value_4, node_value_5,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, node_value_0, node_value_1, node_value_2,
    input  node_value_3, node_value_4, node_value_5,
    output ready
  );
endinterface

interface p2ti_result_if;
  import p2ti_pkg::*;
  logic valid;
  logic ready;
  q_t   interpolated;
  logic overflow;

  modport source (output valid, interpolated, overflow, input ready);
  modport sink (input valid, interpolated, overflow, output ready);
endinterface

interface p2ti_cfg_if;
  import p2ti_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  q_t                   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/p2ti_coord.sv
// ----------------------------------------------------------------------------
// p2ti_coord
// Four-stage map from the query point to reference coordinates a and b.
// ----------------------------------------------------------------------------
module p2ti_coord (
  input  logic               clk,
  input  logic               rst,
  input  p2ti_pkg::map_cfg_t map_cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  p2ti_pkg::sample_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output p2ti_pkg::ref_pt_t  out_data
);
  import p2ti_pkg::*;

  logic [3:0] vld;
  logic [3:0] rdy;

  logic signed [D_W-1:0]  dx;
  logic signed [D_W-1:0]  dy;
  node_vec_t              node1;
  logic signed [MP_W-1:0] pax;
  logic signed [MP_W-1:0] pay;
  logic signed [MP_W-1:0] pbx;
  logic signed [MP_W-1:0] pby;
  node_vec_t              node2;
  logic signed [MS_W-1:0] suma;
  logic signed [MS_W-1:0] sumb;
  node_vec_t              node3;
  logic signed [MS_W-1:0] rnd_a;
  logic signed [MS_W-1:0] rnd_b;
  sat_q_t                 sat_a;
  sat_q_t                 sat_b;

  // stall chain: a stage takes new data when empty or when it drains
  assign rdy[3]    = !vld[3] || out_ready;
  assign rdy[2]    = !vld[2] || rdy[3];
  assign rdy[1]    = !vld[1] || rdy[2];
  assign rdy[0]    = !vld[0] || rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
    end
  end

  // stage 1: offset from vertex zero
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dx    <= D_W'($signed(in_data.point_x)) - D_W'($signed(map_cfg.origin_x));
      dy    <= D_W'($signed(in_data.point_y)) - D_W'($signed(map_cfg.origin_y));
      node1 <= in_data.node;
    end
  end

  // stage 2: inverse map products
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      pax   <= MP_W'($signed(map_cfg.map_a_x)) * MP_W'(dx);
      pay   <= MP_W'($signed(map_cfg.map_a_y)) * MP_W'(dy);
      pbx   <= MP_W'($signed(map_cfg.map_b_x)) * MP_W'(dx);
      pby   <= MP_W'($signed(map_cfg.map_b_y)) * MP_W'(dy);
      node2 <= node1;
    end
  end

  // stage 3: product sums
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      suma  <= MS_W'(pax) + MS_W'(pay);
      sumb  <= MS_W'(pbx) + MS_W'(pby);
      node3 <= node2;
    end
  end

  // stage 4: round half up, drop fraction, clip
  always_comb begin
    rnd_a = (suma + MS_W'(HALF_Q)) >>> FRAC_BITS;
    rnd_b = (sumb + MS_W'(HALF_Q)) >>> FRAC_BITS;
    sat_a = sat_q(ACC_W'(rnd_a));
    sat_b = sat_q(ACC_W'(rnd_b));
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      out_data.a    <= sat_a.value;
      out_data.b    <= sat_b.value;
      out_data.sat  <= sat_a.clip || sat_b.clip;
      out_data.node <= node3;
    end
  end

endmodule

FILE: hdl/p2ti_shape.sv
// ----------------------------------------------------------------------------
// p2ti_shape
// Two-stage evaluation of the six quadratic shape functions at (a, b).
// ----------------------------------------------------------------------------
module p2ti_shape (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  p2ti_pkg::ref_pt_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output p2ti_pkg::shape_pt_t out_data
);
  import p2ti_pkg::*;

  logic [1:0] vld;
  logic [1:0] rdy;

  logic signed [S_W-1:0]  s;
  logic signed [T0_W-1:0] t0;
  logic signed [T1_W-1:0] t1;
  logic signed [T1_W-1:0] t2;
  q_t                     a;
  q_t                     b;
  logic                   sat;
  node_vec_t              node;

  assign rdy[1]    = !vld[1] || out_ready;
  assign rdy[0]    = !vld[0] || rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = vld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
    end
  end

  // stage 5: linear terms s, 2s - one, 2a - one, 2b - one
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s    <= S_W'(ONE) - S_W'($signed(in_data.a)) - S_W'($signed(in_data.b));
      t0   <= T0_W'(ONE) - (T0_W'($signed(in_data.a)) <<< 1)
              - (T0_W'($signed(in_data.b)) <<< 1);
      t1   <= (T1_W'($signed(in_data.a)) <<< 1) - T1_W'(ONE);
      t2   <= (T1_W'($signed(in_data.b)) <<< 1) - T1_W'(ONE);
      a    <= in_data.a;
      b    <= in_data.b;
      sat  <= in_data.sat;
      node <= in_data.node;
    end
  end

  // stage 6: shape products, corners then edge midpoints
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      out_data.shape[0] <= SH_W'(s) * SH_W'(t0);
      out_data.shape[1] <= SH_W'(a) * SH_W'(t1);
      out_data.shape[2] <= SH_W'(b) * SH_W'(t2);
      out_data.shape[3] <= (SH_W'(a) * SH_W'(s)) <<< 2;
      out_data.shape[4] <= (SH_W'(a) * SH_W'(b)) <<< 2;
      out_data.shape[5] <= (SH_W'(b) * SH_W'(s)) <<< 2;
      out_data.sat      <= sat;
      out_data.node     <= node;
    end
  end

endmodule

FILE: hdl/p2ti_dot.sv
// ----------------------------------------------------------------------------
// p2ti_dot
// Six-stage dot product of shape values and node values, round and clip.
// ----------------------------------------------------------------------------
module p2ti_dot (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  p2ti_pkg::shape_pt_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output p2ti_pkg::result_t   out_data
);
  import p2ti_pkg::*;

  logic [5:0] vld;
  logic [5:0] rdy;

  logic signed [PLO_W-1:0] plo  [NODES];
  logic signed [PHI_W-1:0] phi  [NODES];
  logic signed [ACC_W-1:0] lane [NODES];
  logic signed [ACC_W-1:0] pair [3];
  logic signed [ACC_W-1:0] q01;
  logic signed [ACC_W-1:0] q2;
  logic signed [ACC_W-1:0] total;
  logic [4:0]              sat;
  logic signed [ACC_W-1:0] rnd;
  sat_q_t                  res;

  assign rdy[5]    = !vld[5] || out_ready;
  assign rdy[4]    = !vld[4] || rdy[5];
  assign rdy[3]    = !vld[3] || rdy[4];
  assign rdy[2]    = !vld[2] || rdy[3];
  assign rdy[1]    = !vld[1] || rdy[2];
  assign rdy[0]    = !vld[0] || rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = vld[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
      if (rdy[4]) vld[4] <= vld[3];
      if (rdy[5]) vld[5] <= vld[4];
    end
  end

  // stage 7: node value times low and high part of each shape value
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int i = 0; i < NODES; i++) begin
        plo[i] <= PLO_W'($signed(in_data.node[i]))
                  * PLO_W'($signed({1'b0, in_data.shape[i][SPLIT-1:0]}));
        phi[i] <= PHI_W'($signed(in_data.node[i]))
                  * PHI_W'($signed(in_data.shape[i][SH_W-1:SPLIT]));
      end
      sat[0] <= in_data.sat;
    end
  end

  // stage 8: join partial products per lane
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < NODES; i++) begin
        lane[i] <= (ACC_W'(phi[i]) <<< SPLIT) + ACC_W'(plo[i]);
      end
      sat[1] <= sat[0];
    end
  end

  // stage 9: pairwise sums
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      pair[0] <= lane[0] + lane[1];
      pair[1] <= lane[2] + lane[3];
      pair[2] <= lane[4] + lane[5];
      sat[2]  <= sat[1];
    end
  end

  // stage 10: second level of the adder tree
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      q01    <= pair[0] + pair[1];
      q2     <= pair[2];
      sat[3] <= sat[2];
    end
  end

  // stage 11: full sum
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      total  <= q01 + q2;
      sat[4] <= sat[3];
    end
  end

  // stage 12: round half up at twice the fraction, clip, output register
  always_comb begin
    rnd = (total + HALF_ACC) >>> (2*FRAC_BITS);
    res = sat_q(rnd);
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      out_data.interpolated <= res.value;
      out_data.overflow     <= res.clip || sat[4];
    end
  end

endmodule

FILE: hdl/p2_triangle_interpolator.sv
// ----------------------------------------------------------------------------
// p2_triangle_interpolator
// Quadratic triangle element interpolation of six node values at a point.
// ----------------------------------------------------------------------------
// Fully pipelined: one sample transaction is taken every clock while the full
// pipeline is not stalled; its depth is set by the multiplier chain (map
// products, shape products, node products split in two halves) and the adder
// tree behind it. Every stage holds its own valid bit, so when the result
// channel stalls only stages that are full stop and bubbles still close up,
// and while a result waits the sample channel still fills remaining bubbles.
// Configuration writes take effect at once; write them only while no sample
// is in flight.
module p2_triangle_interpolator (
  input  logic                 clk,
  input  logic                 rst,
  p2ti_sample_if.sink          sample,
  p2ti_result_if.source        result,
  p2ti_cfg_if.sink             cfg
);
  import p2ti_pkg::*;

  map_cfg_t  map_cfg;
  sample_t   sample_data;
  ref_pt_t   coord_data;
  shape_pt_t shape_data;
  result_t   dot_data;
  logic      coord_valid;
  logic      coord_ready;
  logic      shape_valid;
  logic      shape_ready;

  // configuration registers, unknown indexes ignored
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_cfg.origin_x <= '0;
      map_cfg.origin_y <= '0;
      map_cfg.map_a_x  <= Q_W'(ONE);
      map_cfg.map_a_y  <= '0;
      map_cfg.map_b_x  <= '0;
      map_cfg.map_b_y  <= Q_W'(ONE);
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_ORIGIN_X: map_cfg.origin_x <= cfg.data;
        REG_ORIGIN_Y: map_cfg.origin_y <= cfg.data;
        REG_MAP_A_X:  map_cfg.map_a_x  <= cfg.data;
        REG_MAP_A_Y:  map_cfg.map_a_y  <= cfg.data;
        REG_MAP_B_X:  map_cfg.map_b_x  <= cfg.data;
        REG_MAP_B_Y:  map_cfg.map_b_y  <= cfg.data;
        default: ;
      endcase
    end
  end

  // sample payload
  assign sample_data.point_x = sample.point_x;
  assign sample_data.point_y = sample.point_y;
  assign sample_data.node[0] = sample.node_value_0;
  assign sample_data.node[1] = sample.node_value_1;
  assign sample_data.node[2] = sample.node_value_2;
  assign sample_data.node[3] = sample.node_value_3;
  assign sample_data.node[4] = sample.node_value_4;
  assign sample_data.node[5] = sample.node_value_5;

  p2ti_coord u_coord (
    .clk       (clk),
    .rst       (rst),
    .map_cfg   (map_cfg),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .in_data   (sample_data),
    .out_valid (coord_valid),
    .out_ready (coord_ready),
    .out_data  (coord_data)
  );

  p2ti_shape u_shape (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (coord_valid),
    .in_ready  (coord_ready),
    .in_data   (coord_data),
    .out_valid (shape_valid),
    .out_ready (shape_ready),
    .out_data  (shape_data)
  );

  p2ti_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (shape_valid),
    .in_ready  (shape_ready),
    .in_data   (shape_data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (dot_data)
  );

  // result payload
  assign result.interpolated = dot_data.interpolated;
  assign result.overflow     = dot_data.overflow;

endmodule
